/* rtl/pwpc_pkg.sv */
// Shared codes for the power window priority controller: priorities,
// motor directions, press codes, sequencer phases and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwpc_pkg;

  localparam int unsigned TIMER_WIDTH_DEFAULT = 16;
  localparam int unsigned CFG_DATA_WIDTH      = 16;
  localparam int unsigned CFG_INDEX_WIDTH     = 2;

  localparam logic [15:0] REVERSE_TICKS_RESET = 16'd2000;
  localparam logic [15:0] PAUSE_TICKS_RESET   = 16'd100;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REVERSE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAUSE_TICKS   = 2'd1;

  localparam logic [2:0] PR_IDLE          = 3'd1;
  localparam logic [2:0] PR_RIDER_AUTO    = 3'd2;
  localparam logic [2:0] PR_RIDER_MANUAL  = 3'd3;
  localparam logic [2:0] PR_DRIVER_AUTO   = 3'd4;
  localparam logic [2:0] PR_DRIVER_MANUAL = 3'd5;
  localparam logic [2:0] PR_EMERGENCY     = 3'd6;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_STOP = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_MOVING  = 2'd1;
  localparam logic [1:0] PH_PAUSE   = 2'd2;
  localparam logic [1:0] PH_REVERSE = 2'd3;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_DRIVER_UP   = 3'd1;
  localparam logic [2:0] EV_DRIVER_DOWN = 3'd2;
  localparam logic [2:0] EV_RIDER_UP    = 3'd3;
  localparam logic [2:0] EV_RIDER_DOWN  = 3'd4;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       emergency_active;
    logic [2:0] owner_priority;
  } result_t;

endpackage

`default_nettype wire

/* rtl/power_window_priority_controller.sv */
// Power window priority controller with obstacle reversal.
// Depends on pwpc_pkg for codes and the result type.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per sample carries
//   the qualified press, button levels, limit switches, obstacle, lock line
//   and the time tick. Output channel (out_valid / out_stall): one result
//   transaction per input: motor drive, emergency flag and owner priority.
//   Configuration channel (cfg_valid / cfg_ready): index 0 reverse_ticks,
//   index 1 pause_ticks; other indexes are taken and dropped. Always ready.
//   Each taken input's result is registered in the output buffer.
//   Throughput: one transaction per cycle while in_stall is low; the control
//   state updates from the registered state and the incoming sample.
//   Stall: a two-entry output buffer (result register plus skid) lets one
//   more input be taken while a result waits; in_stall rises only when
//   both entries are full.
//   Reset: synchronous rst returns the controller to idle with the motor
//   stopped, priority 1, registers at 2000 and 100, and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module power_window_priority_controller #(
  parameter int unsigned TIMER_WIDTH = pwpc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pwpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [pwpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [2:0]                           press_event,
  input  wire logic                                 press_held,
  input  wire logic                                 driver_up_level,
  input  wire logic                                 driver_down_level,
  input  wire logic                                 rider_up_level,
  input  wire logic                                 rider_down_level,
  input  wire logic                                 top_reached,
  input  wire logic                                 bottom_reached,
  input  wire logic                                 obstacle,
  input  wire logic                                 lock_line,
  input  wire logic                                 tick,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                motor_drive,
  output logic                                      emergency_active,
  output logic [2:0]                                owner_priority
);

  import pwpc_pkg::*;

  typedef struct packed {
    logic [2:0]             active_priority;
    logic [1:0]             motor_direction;
    logic [1:0]             phase;
    logic [2:0]             job_source;
    logic                   job_manual;
    logic [TIMER_WIDTH-1:0] emergency_timer;
  } ctrl_t;

  logic [CFG_DATA_WIDTH-1:0] reverse_ticks;
  logic [CFG_DATA_WIDTH-1:0] pause_ticks;
  ctrl_t                     ctrl;
  ctrl_t                     ctrl_next;
  result_t                   res_next;
  result_t                   out_res;
  result_t                   skid_res;
  logic                      skid_valid;
  logic                      in_accept;
  logic                      out_take;

  function automatic logic [TIMER_WIDTH-1:0] clamp_timer(input logic [CFG_DATA_WIDTH-1:0] v);
    logic [TIMER_WIDTH-1:0] c;
    if ((TIMER_WIDTH < CFG_DATA_WIDTH) && ((v >> TIMER_WIDTH) != '0)) begin
      c = '1;
    end else begin
      c = TIMER_WIDTH'(v);
    end
    return c;
  endfunction

  function automatic ctrl_t idle_state(input ctrl_t s);
    ctrl_t r;
    r                 = s;
    r.phase           = PH_IDLE;
    r.motor_direction = DIR_STOP;
    r.active_priority = PR_IDLE;
    r.job_source      = EV_NONE;
    r.job_manual      = 1'b0;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_ticks <= REVERSE_TICKS_RESET;
      pause_ticks   <= PAUSE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REVERSE_TICKS: reverse_ticks <= cfg_data;
        REG_PAUSE_TICKS:   pause_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                   driver;
    logic                   want_up;
    logic [2:0]             pr;
    logic [1:0]             opposite;
    logic                   level;
    logic                   released;
    logic [TIMER_WIDTH-1:0] rev;
    logic [TIMER_WIDTH-1:0] dec;

    ctrl_next = ctrl;
    driver    = (press_event == EV_DRIVER_UP) || (press_event == EV_DRIVER_DOWN);
    want_up   = (press_event == EV_DRIVER_UP) || (press_event == EV_RIDER_UP);
    pr        = driver ? (press_held ? PR_DRIVER_MANUAL : PR_DRIVER_AUTO)
                       : (press_held ? PR_RIDER_MANUAL : PR_RIDER_AUTO);
    opposite  = want_up ? DIR_DOWN : DIR_UP;
    rev       = clamp_timer(reverse_ticks);
    dec       = ctrl.emergency_timer - TIMER_WIDTH'(1);
    level     = 1'b0;
    released  = 1'b0;

    case (ctrl.phase)
      PH_PAUSE: begin
        if (ctrl.emergency_timer == '0) begin
          ctrl_next.phase           = PH_REVERSE;
          ctrl_next.motor_direction = DIR_DOWN;
          ctrl_next.emergency_timer = rev;
          if (bottom_reached || (rev == '0)) begin
            ctrl_next = idle_state(ctrl_next);
          end
        end else if (tick) begin
          ctrl_next.emergency_timer = dec;
        end
      end
      PH_REVERSE: begin
        ctrl_next.motor_direction = DIR_DOWN;
        if (bottom_reached || (ctrl.emergency_timer == '0)) begin
          ctrl_next = idle_state(ctrl_next);
        end else if (tick) begin
          ctrl_next.emergency_timer = dec;
          if (dec == '0) begin
            ctrl_next = idle_state(ctrl_next);
          end
        end
      end
      default: begin
        if ((press_event inside {[EV_DRIVER_UP:EV_RIDER_DOWN]}) && !(!driver && lock_line)
            && (pr > ctrl.active_priority)) begin
          if (ctrl.motor_direction == opposite) begin
            ctrl_next = idle_state(ctrl_next);
          end else begin
            ctrl_next.active_priority = pr;
            ctrl_next.phase           = PH_MOVING;
            ctrl_next.job_source      = press_event;
            ctrl_next.job_manual      = press_held;
          end
        end

        if (ctrl_next.phase == PH_MOVING) begin
          case (ctrl_next.job_source)
            EV_DRIVER_UP:   level = driver_up_level;
            EV_DRIVER_DOWN: level = driver_down_level;
            EV_RIDER_UP:    level = rider_up_level;
            default:        level = rider_down_level;
          endcase
          released = ctrl_next.job_manual && !level;
          if ((ctrl_next.job_source == EV_DRIVER_UP) || (ctrl_next.job_source == EV_RIDER_UP))
          begin
            if (obstacle) begin
              ctrl_next.phase           = PH_PAUSE;
              ctrl_next.motor_direction = DIR_STOP;
              ctrl_next.active_priority = PR_EMERGENCY;
              ctrl_next.job_source      = EV_NONE;
              ctrl_next.job_manual      = 1'b0;
              ctrl_next.emergency_timer = clamp_timer(pause_ticks);
            end else if (top_reached || released) begin
              ctrl_next = idle_state(ctrl_next);
            end else begin
              ctrl_next.motor_direction = DIR_UP;
            end
          end else begin
            if (bottom_reached || released) begin
              ctrl_next = idle_state(ctrl_next);
            end else begin
              ctrl_next.motor_direction = DIR_DOWN;
            end
          end
        end else begin
          ctrl_next = idle_state(ctrl_next);
        end
      end
    endcase

    res_next.motor_drive      = ctrl_next.motor_direction;
    res_next.emergency_active = (ctrl_next.phase == PH_PAUSE) || (ctrl_next.phase == PH_REVERSE);
    res_next.owner_priority   = ctrl_next.active_priority;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= idle_state(ctrl_t'('0));
    end else if (in_accept) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_accept) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_accept) begin
      skid_res   <= res_next;
      skid_valid <= 1'b1;
    end
  end

  assign motor_drive      = out_res.motor_drive;
  assign emergency_active = out_res.emergency_active;
  assign owner_priority   = out_res.owner_priority;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending result");

  a_emergency_owner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && emergency_active) |-> (owner_priority == PR_EMERGENCY))
    else $error("emergency result without emergency priority");

  a_idle_consistent: assert property (@(posedge clk) disable iff (rst)
    (ctrl.phase == PH_IDLE) |-> ((ctrl.motor_direction == DIR_STOP)
                                 && (ctrl.active_priority == PR_IDLE)))
    else $error("idle phase with motor running or priority held");

  a_pause_stopped: assert property (@(posedge clk) disable iff (rst)
    (ctrl.phase == PH_PAUSE) |-> ((ctrl.motor_direction == DIR_STOP)
                                  && (ctrl.active_priority == PR_EMERGENCY)))
    else $error("motor running during obstacle pause");

endmodule

`default_nettype wire

/* tb/power_window_priority_controller_tb.sv */
// Self-checking testbench for the power window priority controller: directed
// priority and emergency cases, timer extremes and random button traffic.
// Depends on pwpc_pkg and rtl/power_window_priority_controller.sv.
`timescale 1ns / 1ps

module power_window_priority_controller_tb;
  import pwpc_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [2:0] EV_RSVD_5 = 3'd5;
  localparam logic [2:0] EV_RSVD_6 = 3'd6;
  localparam logic [2:0] EV_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [2:0] press_event;
    logic       press_held;
    logic       du;
    logic       dd;
    logic       ru;
    logic       rd;
    logic       top;
    logic       bottom;
    logic       obst;
    logic       lock;
    logic       tck;
  } window_input_t;

  localparam int WIN_BITS = $bits(window_input_t);

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] press_event = '0;
  logic press_held = 1'b0;
  logic driver_up_level = 1'b0;
  logic driver_down_level = 1'b0;
  logic rider_up_level = 1'b0;
  logic rider_down_level = 1'b0;
  logic top_reached = 1'b0;
  logic bottom_reached = 1'b0;
  logic obstacle = 1'b0;
  logic lock_line = 1'b0;
  logic tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] motor_drive;
  logic emergency_active;
  logic [2:0] owner_priority;

  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int mismatches = 0;
  result_t expected_commands[$];

  // controller state as predicted
  logic [15:0] cfg_reverse = REVERSE_TICKS_RESET;
  logic [15:0] cfg_pause = PAUSE_TICKS_RESET;
  logic [1:0] m_phase = PH_IDLE;
  logic [1:0] m_dir = DIR_STOP;
  logic [2:0] m_prio = PR_IDLE;
  logic [2:0] m_src = EV_NONE;
  logic m_manual = 1'b0;
  logic [15:0] m_timer = '0;

  power_window_priority_controller i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .press_event      (press_event),
    .press_held       (press_held),
    .driver_up_level  (driver_up_level),
    .driver_down_level(driver_down_level),
    .rider_up_level   (rider_up_level),
    .rider_down_level (rider_down_level),
    .top_reached      (top_reached),
    .bottom_reached   (bottom_reached),
    .obstacle         (obstacle),
    .lock_line        (lock_line),
    .tick             (tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_drive      (motor_drive),
    .emergency_active (emergency_active),
    .owner_priority   (owner_priority)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd40_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic park_window();
    m_phase = PH_IDLE;
    m_dir = DIR_STOP;
    m_prio = PR_IDLE;
    m_src = EV_NONE;
    m_manual = 1'b0;
  endtask

  task automatic predict_motor_command(input window_input_t w, output result_t r);
    logic driver;
    logic [1:0] want;
    logic [1:0] opposite;
    logic [2:0] prio;
    logic level;
    logic released;
    case (m_phase)
      PH_PAUSE: begin
        if (m_timer == 16'd0) begin
          m_phase = PH_REVERSE;
          m_dir = DIR_DOWN;
          m_timer = cfg_reverse;
          if (w.bottom || m_timer == 16'd0) park_window();
        end else if (w.tck) begin
          m_timer = m_timer - 16'd1;
        end
      end
      PH_REVERSE: begin
        m_dir = DIR_DOWN;
        if (w.bottom || m_timer == 16'd0) begin
          park_window();
        end else if (w.tck) begin
          m_timer = m_timer - 16'd1;
          if (m_timer == 16'd0) park_window();
        end
      end
      default: begin
        if (w.press_event >= EV_DRIVER_UP && w.press_event <= EV_RIDER_DOWN) begin
          driver = (w.press_event <= EV_DRIVER_DOWN);
          want = (w.press_event == EV_DRIVER_UP || w.press_event == EV_RIDER_UP) ?
                 DIR_UP : DIR_DOWN;
          if (driver) prio = w.press_held ? PR_DRIVER_MANUAL : PR_DRIVER_AUTO;
          else prio = w.press_held ? PR_RIDER_MANUAL : PR_RIDER_AUTO;
          if (!(!driver && w.lock) && prio > m_prio) begin
            opposite = (want == DIR_UP) ? DIR_DOWN : DIR_UP;
            if (m_dir == opposite) begin
              park_window();
            end else begin
              m_prio = prio;
              m_phase = PH_MOVING;
              m_src = w.press_event;
              m_manual = w.press_held;
            end
          end
        end
        if (m_phase == PH_MOVING) begin
          case (m_src)
            EV_DRIVER_UP: level = w.du;
            EV_DRIVER_DOWN: level = w.dd;
            EV_RIDER_UP: level = w.ru;
            default: level = w.rd;
          endcase
          released = m_manual && !level;
          if (m_src == EV_DRIVER_UP || m_src == EV_RIDER_UP) begin
            if (w.obst) begin
              m_phase = PH_PAUSE;
              m_dir = DIR_STOP;
              m_prio = PR_EMERGENCY;
              m_src = EV_NONE;
              m_manual = 1'b0;
              m_timer = cfg_pause;
            end else if (w.top || released) begin
              park_window();
            end else begin
              m_dir = DIR_UP;
            end
          end else begin
            if (w.bottom || released) park_window();
            else m_dir = DIR_DOWN;
          end
        end else begin
          park_window();
        end
      end
    endcase
    r.motor_drive = m_dir;
    r.emergency_active = (m_phase == PH_PAUSE) || (m_phase == PH_REVERSE);
    r.owner_priority = m_prio;
  endtask

  function automatic window_input_t make_input(logic [2:0] ev, logic held, logic [3:0] lv,
                                               logic at_top, logic at_bottom, logic obst,
                                               logic lock, logic tck);
    window_input_t w;
    w.press_event = ev;
    w.press_held = held;
    {w.du, w.dd, w.ru, w.rd} = lv;
    w.top = at_top;
    w.bottom = at_bottom;
    w.obst = obst;
    w.lock = lock;
    w.tck = tck;
    return w;
  endfunction

  task automatic send_window_input(input window_input_t w);
    int gap;
    result_t cmd;
    gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    press_event <= w.press_event;
    press_held <= w.press_held;
    driver_up_level <= w.du;
    driver_down_level <= w.dd;
    rider_up_level <= w.ru;
    rider_down_level <= w.rd;
    top_reached <= w.top;
    bottom_reached <= w.bottom;
    obstacle <= w.obst;
    lock_line <= w.lock;
    tick <= w.tck;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_motor_command(w, cmd);
    expected_commands.push_back(cmd);
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REVERSE_TICKS: cfg_reverse = val;
      REG_PAUSE_TICKS: cfg_pause = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_cmd;
    if (!rst && out_valid && !out_stall) begin
      if (expected_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: drive %0d emergency %0d priority %0d",
                   motor_drive, emergency_active, owner_priority);
      end else begin
        exp_cmd = expected_commands.pop_front();
        if (motor_drive !== exp_cmd.motor_drive ||
            emergency_active !== exp_cmd.emergency_active ||
            owner_priority !== exp_cmd.owner_priority) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: drive %0d/%0d emergency %0d/%0d priority %0d/%0d",
                     $realtime, exp_cmd.motor_drive, motor_drive,
                     exp_cmd.emergency_active, emergency_active,
                     exp_cmd.owner_priority, owner_priority);
        end
      end
    end
  end

  task automatic test_priority_rules();
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_RIDER_UP, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    // opposite passenger manual stops the auto move
    send_window_input(make_input(EV_RIDER_DOWN, 1'b1, 4'b0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_DOWN, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_RIDER_UP, 1'b1, 4'b0010, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_window_input(make_input(EV_DRIVER_DOWN, 1'b1, 4'b0100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_RIDER_DOWN, 1'b0, 4'b0001, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_window_input(make_input(EV_RSVD_5, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_RSVD_6, 1'b1, 4'b1111, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_window_input(make_input(EV_RSVD_7, 1'b1, 4'b1111, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_UP, 1'b0, 4'b0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_DOWN, 1'b0, 4'b0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_UP, 1'b1, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_UP, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_UP, 1'b1, 4'b1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_obstacle_reversal();
    write_register(REG_PAUSE_TICKS, 16'd0);
    write_register(REG_REVERSE_TICKS, 16'd0);
    send_window_input(make_input(EV_DRIVER_DOWN, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_window_input(make_input(EV_DRIVER_UP, 1'b0, 4'b0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    // equal priority up press does not take over; obstacle and top ignored
    send_window_input(make_input(EV_DRIVER_UP, 1'b0, 4'b0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    send_window_input(make_input(EV_DRIVER_UP, 1'b1, 4'b1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_drained();
    write_register(REG_PAUSE_TICKS, 16'd2);
    write_register(REG_REVERSE_TICKS, 16'd3);
    send_window_input(make_input(EV_RIDER_UP, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_window_input(make_input(EV_DRIVER_UP, 1'b1, 4'b1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_timer_extremes();
    write_register(REG_SPARE_2, 16'hFFFF);
    write_register(REG_SPARE_3, 16'h5A5A);
    write_register(REG_PAUSE_TICKS, 16'd3);
    write_register(REG_REVERSE_TICKS, 16'hFFFF);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_window_input(make_input(EV_DRIVER_UP, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    // load the reversal from full scale, then end it on the bottom limit
    repeat (24)
      send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_window_input(make_input(EV_NONE, 1'b0, 4'b0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    wait_drained();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    window_input_t w;
    logic [2:0] holding;
    holding = EV_NONE;
    for (int round = 0; round < 7; round++) begin
      wait_drained();
      case (round)
        0: begin
          write_register(REG_PAUSE_TICKS, 16'd0);
          write_register(REG_REVERSE_TICKS, 16'd0);
        end
        1: begin
          write_register(REG_PAUSE_TICKS, 16'd0);
          write_register(REG_REVERSE_TICKS, 16'd1);
        end
        default: begin
          write_register(REG_PAUSE_TICKS, 16'($urandom_range(0, 6)));
          write_register(REG_REVERSE_TICKS, 16'($urandom_range(1, 15)));
        end
      endcase
      gaps_on = (round < 5);
      stalls_on = (round < 5);
      repeat (200) begin
        if ($urandom_range(0, 9) == 0) begin
          w = WIN_BITS'($urandom);
        end else begin
          if ($urandom_range(0, 6) == 0) holding = 3'($urandom_range(0, 4));
          w = '0;
          if ($urandom_range(0, 3) == 0) begin
            w.press_event = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                            3'($urandom_range(1, 4));
            w.press_held = 1'($urandom_range(0, 1));
            if (w.press_held && w.press_event <= EV_RIDER_DOWN) holding = w.press_event;
          end
          w.du = (holding == EV_DRIVER_UP) || ($urandom_range(0, 9) == 0);
          w.dd = (holding == EV_DRIVER_DOWN) || ($urandom_range(0, 9) == 0);
          w.ru = (holding == EV_RIDER_UP) || ($urandom_range(0, 9) == 0);
          w.rd = (holding == EV_RIDER_DOWN) || ($urandom_range(0, 9) == 0);
          w.top = ($urandom_range(0, 11) == 0);
          w.bottom = ($urandom_range(0, 11) == 0);
          w.obst = ($urandom_range(0, 15) == 0);
          w.lock = ($urandom_range(0, 2) == 0);
          w.tck = ($urandom_range(0, 3) != 0);
        end
        send_window_input(w);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_priority_rules();
    test_obstacle_reversal();
    test_timer_extremes();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
